[src/wrg_pkg.sv]
package wrg_pkg;

  localparam int POOL_WORDS = 16;
  localparam int POOL_AW    = $clog2(POOL_WORDS);
  localparam int WORD_W     = 32;

  localparam logic CMD_GENERATE = 1'b0;
  localparam logic CMD_SEED     = 1'b1;

  localparam logic [POOL_AW-1:0] TAP_A   = POOL_AW'(13);
  localparam logic [POOL_AW-1:0] TAP_B   = POOL_AW'(9);
  localparam logic [POOL_AW-1:0] TAP_PRV = POOL_AW'(POOL_WORDS - 1);

  localparam logic [WORD_W-1:0] TEMPER_MASK = 32'hda44_2d24;
  localparam logic [WORD_W-1:0] FILL_MULT   = 32'd1812433253;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_G_A,
    ST_G_B,
    ST_G_C,
    ST_G_D,
    ST_G_Z,
    ST_G_OUT,
    ST_F_RD,
    ST_F_MUL,
    ST_F_WR
  } wrg_state_t;

  typedef enum logic [2:0] {
    RD_POS,
    RD_TAP_A,
    RD_TAP_B,
    RD_PRV,
    RD_FILL
  } wrg_rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_Z3,
    WR_Z4,
    WR_FILL
  } wrg_wr_sel_t;

  typedef struct packed {
    logic        accept;
    logic        rd_en;
    wrg_rd_sel_t rd_sel;
    logic        cap_a;
    logic        cap_z1;
    logic        cap_z2;
    logic        cap_z4;
    logic        cap_prod;
    wrg_wr_sel_t wr_sel;
    logic        out_load;
    logic        fill_step;
  } wrg_cmd_t;

  typedef struct packed {
    logic fill_start;
    logic fill_last;
    logic out_free;
  } wrg_stat_t;

endpackage

[src/wrg_ram.sv]
module wrg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/wrg_ctrl.sv]
module wrg_ctrl
  import wrg_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_stall,
  input  logic      command,
  input  wrg_stat_t stat,
  output wrg_cmd_t  cmd
);

  wrg_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign cmd_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = RD_POS;
    cmd.wr_sel = WR_NONE;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd.accept = 1'b1;
          if (command == CMD_GENERATE) begin
            state_next = ST_G_A;
          end else if (stat.fill_start) begin
            state_next = ST_F_RD;
          end
        end
      end
      ST_G_A: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_POS;
        state_next = ST_G_B;
      end
      ST_G_B: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_TAP_A;
        cmd.cap_a  = 1'b1;
        state_next = ST_G_C;
      end
      ST_G_C: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_TAP_B;
        cmd.cap_z1 = 1'b1;
        state_next = ST_G_D;
      end
      ST_G_D: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_PRV;
        cmd.cap_z2 = 1'b1;
        state_next = ST_G_Z;
      end
      ST_G_Z: begin
        cmd.cap_z4 = 1'b1;
        cmd.wr_sel = WR_Z3;
        state_next = ST_G_OUT;
      end
      ST_G_OUT: begin
        // hold until the output register can take the new word
        if (stat.out_free) begin
          cmd.wr_sel   = WR_Z4;
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_F_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_FILL;
        state_next = ST_F_MUL;
      end
      ST_F_MUL: begin
        cmd.cap_prod = 1'b1;
        state_next   = ST_F_WR;
      end
      ST_F_WR: begin
        cmd.wr_sel    = WR_FILL;
        cmd.fill_step = 1'b1;
        state_next    = stat.fill_last ? ST_IDLE : ST_F_RD;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[src/wrg_datapath.sv]
module wrg_datapath
  import wrg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  wrg_cmd_t          cmd,
  output wrg_stat_t         stat,
  input  logic              command,
  input  logic [WORD_W-1:0] seed_word,
  input  logic              seed_last,
  input  logic [5:0]        bits_requested,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [WORD_W-1:0] random_value
);

  logic [POOL_AW-1:0]    pos;
  logic [POOL_AW:0]      seed_count;
  logic [POOL_AW:0]      count_new;
  logic                  seed_store;
  logic [POOL_AW-1:0]    fill_i;
  logic [POOL_AW-1:0]    fill_n;
  logic [POOL_WORDS-1:0] valid;
  logic                  rd_valid;
  logic [5:0]            bits_q;
  logic [5:0]            bits_eff;

  logic [WORD_W-1:0] a_q, z1_q, z2_q, z4_q, prod_q;
  logic [WORD_W-1:0] ram_rdata, rdata;
  logic [WORD_W-1:0] z1, z2, z3, z4, fill_sh, fill_x;

  logic                wr_en, rd_en;
  logic [POOL_AW-1:0]  wr_addr, rd_addr;
  logic [WORD_W-1:0]   wr_data;

  assign seed_store = (seed_count < (POOL_AW + 1)'(POOL_WORDS));
  assign count_new  = seed_count + (POOL_AW + 1)'(seed_store);

  assign stat.fill_start = (command == CMD_SEED) && seed_last &&
                           (count_new < (POOL_AW + 1)'(POOL_WORDS));
  assign stat.fill_last  = (fill_i == POOL_AW'(POOL_WORDS - 1));
  assign stat.out_free   = !result_valid || !result_stall;

  // never-written words read as zero
  assign rdata = rd_valid ? ram_rdata : '0;

  assign z1 = (a_q ^ (a_q << 16)) ^ (rdata ^ (rdata << 15));
  assign z2 = rdata ^ (rdata >> 11);
  assign z3 = z1_q ^ z2_q;
  assign z4 = (rdata ^ (rdata << 2)) ^ (z1_q ^ (z1_q << 18)) ^ (z2_q << 28)
              ^ (z3 ^ ((z3 << 5) & TEMPER_MASK));

  // arithmetic shift by 30 of the sign-extended word, low 32 bits
  assign fill_sh = {{(WORD_W - 2){rdata[WORD_W-1]}}, rdata[WORD_W-1:WORD_W-2]};
  assign fill_x  = rdata ^ fill_sh;

  assign bits_eff = (bits_q > 6'd32) ? 6'd32 : bits_q;

  assign rd_en = cmd.rd_en;
  always_comb begin
    unique case (cmd.rd_sel)
      RD_POS:   rd_addr = pos;
      RD_TAP_A: rd_addr = pos + TAP_A;
      RD_TAP_B: rd_addr = pos + TAP_B;
      RD_PRV:   rd_addr = pos + TAP_PRV;
      RD_FILL:  rd_addr = fill_i - fill_n;
      default:  rd_addr = pos;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = seed_count[POOL_AW-1:0];
    wr_data = seed_word;
    if (cmd.accept && (command == CMD_SEED)) begin
      wr_en = seed_store;
    end else begin
      case (cmd.wr_sel)
        WR_Z3: begin
          wr_en   = 1'b1;
          wr_addr = pos;
          wr_data = z3;
        end
        WR_Z4: begin
          wr_en   = 1'b1;
          wr_addr = pos + TAP_PRV;
          wr_data = z4_q;
        end
        WR_FILL: begin
          wr_en   = 1'b1;
          wr_addr = fill_i;
          wr_data = prod_q + WORD_W'(fill_i);
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  wrg_ram #(
    .WIDTH(WORD_W),
    .DEPTH(POOL_WORDS)
  ) u_pool (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= '0;
      seed_count   <= '0;
      valid        <= '0;
      rd_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
      end
      if (cmd.accept && (command == CMD_SEED)) begin
        if (seed_last) begin
          seed_count <= '0;
          pos        <= '0;
        end else begin
          seed_count <= count_new;
        end
      end
      if (cmd.out_load) begin
        pos <= pos + TAP_PRV;
      end
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      bits_q <= bits_requested;
      fill_n <= count_new[POOL_AW-1:0];
      fill_i <= count_new[POOL_AW-1:0];
    end
    if (cmd.fill_step) begin
      fill_i <= fill_i + POOL_AW'(1);
    end
    if (cmd.cap_a) begin
      a_q <= rdata;
    end
    if (cmd.cap_z1) begin
      z1_q <= z1;
    end
    if (cmd.cap_z2) begin
      z2_q <= z2;
    end
    if (cmd.cap_z4) begin
      z4_q <= z4;
    end
    if (cmd.cap_prod) begin
      prod_q <= FILL_MULT * fill_x;
    end
    if (cmd.out_load) begin
      random_value <= z4_q >> (6'd32 - bits_eff);
    end
  end

endmodule

[src/well512a_random_generator.sv]
// WELL512a random number generator.
// Command channel (cmd_valid / cmd_stall): each beat carries command,
// seed_word, seed_last and bits_requested. command 1 loads one seed word
// into the 16-word pool (words past the sixteenth are dropped); seed_last
// ends seeding, fills the unseeded words and resets the pool position.
// command 0 advances the generator and returns one result beat.
// Result channel (result_valid / result_stall): random_value holds the top
// bits_requested bits (at most 32) of the new word, right-aligned.
// A generate beat steps through the states G_A, G_B, G_C, G_D, G_Z, G_OUT;
// G_OUT loads the result and returns to idle for the next beat. The pool is
// a single-read-port RAM, so the four pool reads run one per cycle.
// A seed beat is taken in idle; a last seed word with n words stored adds
// a fill of the 16 - n unseeded words (read, multiply, write per word).
// A stalled result holds in the output register; a following generate
// waits in its final step until that register is free.
// Reset (rst, synchronous) makes all pool words read zero, clears the
// position and the seed count; seed the block before use.
module well512a_random_generator
  import wrg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  logic              command,
  input  logic [WORD_W-1:0] seed_word,
  input  logic              seed_last,
  input  logic [5:0]        bits_requested,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [WORD_W-1:0] random_value
);

  wrg_cmd_t  cmd;
  wrg_stat_t stat;

  wrg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .command   (command),
    .stat      (stat),
    .cmd       (cmd)
  );

  wrg_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .command        (command),
    .seed_word      (seed_word),
    .seed_last      (seed_last),
    .bits_requested (bits_requested),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .random_value   (random_value)
  );

endmodule

[src/wrg_checker.sv]
module wrg_checker
  import wrg_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              cmd_valid,
  input logic              cmd_stall,
  input logic              command,
  input logic [WORD_W-1:0] seed_word,
  input logic              seed_last,
  input logic [5:0]        bits_requested,
  input logic              result_valid,
  input logic              result_stall,
  input logic [WORD_W-1:0] random_value
);

  // nothing pending right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !result_valid && !cmd_stall)
    else $error("result or stall active after reset");

  // a stalled result beat stays
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(random_value))
    else $error("stalled result beat dropped or changed");

  // a generate beat keeps the command side busy
  a_gen_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall && !command |=> cmd_stall ##1 cmd_stall)
    else $error("generate beat did not occupy the block");

  // a new result only appears at the end of a generate run
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(cmd_stall))
    else $error("result beat without a generate run");

endmodule

bind well512a_random_generator wrg_checker u_wrg_checker (.*);

[dv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import wrg_pkg::*;

  localparam int   IDLE_LIMIT   = 2000;
  localparam int   DRAIN_CYCLES = 64;
  localparam int   RANDOM_ITEMS = 700;

  typedef struct {
    logic              command;
    logic [WORD_W-1:0] seed_word;
    logic              seed_last;
    logic [5:0]        bits_requested;
    bit                hold;
  } cmd_item_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cmd_valid = 1'b0;
  logic              cmd_stall;
  logic              command = CMD_GENERATE;
  logic [WORD_W-1:0] seed_word = '0;
  logic              seed_last = 1'b0;
  logic [5:0]        bits_requested = 6'd32;
  logic              result_valid;
  logic              result_stall = 1'b0;
  logic [WORD_W-1:0] random_value;

  // generator model state
  logic [WORD_W-1:0] pool_model [POOL_WORDS];
  logic [POOL_AW-1:0] position;
  int                seed_count;

  cmd_item_t         pending [$];
  logic [WORD_W-1:0] expected_values [$];
  cmd_item_t         on_bus;
  int                gap_left;
  int                stall_left;
  int                beats_sent;
  int                beats_received;
  int                idle_cycles;
  int                errors;
  bit                hold_next;

  well512a_random_generator dut (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd_stall     (cmd_stall),
    .command       (command),
    .seed_word     (seed_word),
    .seed_last     (seed_last),
    .bits_requested(bits_requested),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .random_value  (random_value)
  );

  always #5 clk = ~clk;

  task automatic advance_generator(input cmd_item_t it);
    logic [WORD_W-1:0] a, b, c, z0, z1, z2, z3, z4, u, x, word;
    logic [POOL_AW-1:0] im1, t1, t2;
    int n;
    int bits;
    if (it.command == CMD_SEED) begin
      if (seed_count < POOL_WORDS) begin
        pool_model[seed_count] = it.seed_word;
        seed_count++;
      end
      if (it.seed_last) begin
        if (seed_count < POOL_WORDS) begin
          n = seed_count;
          for (int k = n; k < POOL_WORDS; k++) begin
            u = pool_model[k - n];
            x = u ^ WORD_W'($signed(u) >>> 30);
            pool_model[k] = FILL_MULT * x + WORD_W'(k);
          end
        end
        seed_count = 0;
        position = '0;
      end
    end else begin
      im1 = position + TAP_PRV;
      t1 = position + TAP_A;
      t2 = position + TAP_B;
      a = pool_model[position];
      b = pool_model[t1];
      c = pool_model[t2];
      z0 = pool_model[im1];
      z1 = (a ^ (a << 16)) ^ (b ^ (b << 15));
      z2 = c ^ (c >> 11);
      z3 = z1 ^ z2;
      z4 = (z0 ^ (z0 << 2)) ^ (z1 ^ (z1 << 18)) ^ (z2 << 28) ^ (z3 ^ ((z3 << 5) & TEMPER_MASK));
      pool_model[position] = z3;
      pool_model[im1] = z4;
      position = im1;
      bits = (it.bits_requested > 6'd32) ? 32 : int'(it.bits_requested);
      word = (bits == 0) ? '0 : z4 >> (32 - bits);
      expected_values.push_back(word);
    end
  endtask

  task automatic push_item(input logic cmd, input logic [WORD_W-1:0] word, input logic last,
                           input logic [5:0] bits);
    cmd_item_t it;
    it.command = cmd;
    it.seed_word = word;
    it.seed_last = last;
    it.bits_requested = bits;
    it.hold = hold_next;
    hold_next = 1'b0;
    pending.push_back(it);
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return '1;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [5:0] pick_bits();
    if ($urandom_range(0, 7) == 0) return 6'($urandom_range(0, 63));
    return 6'($urandom_range(1, 32));
  endfunction

  // driver
  always @(posedge clk) begin
    logic take;
    logic next_valid;
    int gap_now;
    if (rst) begin
      cmd_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      take = cmd_valid && !cmd_stall;
      next_valid = cmd_valid && !take;
      gap_now = gap_left;
      if (take) begin
        advance_generator(on_bus);
        beats_sent++;
        // some stretches run back to back
        gap_now = ((beats_sent / 64) % 4 == 0) ? 0 : $urandom_range(0, 16);
      end
      if (!next_valid) begin
        if (gap_now > 0) begin
          gap_now--;
        end else if (pending.size() != 0 &&
                     !(pending[0].hold && expected_values.size() != 0)) begin
          on_bus = pending.pop_front();
          next_valid = 1'b1;
          command <= on_bus.command;
          seed_word <= on_bus.seed_word;
          seed_last <= on_bus.seed_last;
          bits_requested <= on_bus.bits_requested;
        end
      end
      cmd_valid <= next_valid;
      gap_left <= gap_now;
    end
  end

  // monitor
  always @(posedge clk) begin
    int stall_now;
    logic [WORD_W-1:0] want;
    if (rst) begin
      result_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      stall_now = stall_left;
      if (result_valid && !result_stall) begin
        beats_received++;
        if (expected_values.size() == 0) begin
          $display("%0t: unexpected result beat, actual %h", $time, random_value);
          errors++;
        end else begin
          want = expected_values.pop_front();
          if (random_value !== want) begin
            $display("%0t: random_value mismatch, expected %h actual %h",
                     $time, want, random_value);
            errors++;
          end
        end
        stall_now = ((beats_received / 48) % 4 == 1) ? 0 : $urandom_range(0, 16);
      end
      if (stall_now > 0) begin
        result_stall <= 1'b1;
        stall_left <= stall_now - 1;
      end else begin
        result_stall <= 1'b0;
        stall_left <= 0;
      end
    end
  end

  // watchdog: cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst) begin
      if ((cmd_valid && !cmd_stall) || (result_valid && !result_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("well512a_random_generator verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int len;
    int ngen;
    bit hold_done;
    hold_done = 1'b0;
    foreach (pool_model[k]) pool_model[k] = '0;
    position = '0;
    seed_count = 0;

    // unseeded pool gives zero
    push_item(CMD_GENERATE, '1, 1'b1, 6'd32);
    push_item(CMD_GENERATE, '0, 1'b0, 6'd0);
    // single word seed, negative word exercises sign extension in the fill
    push_item(CMD_SEED, 32'hffff_ffff, 1'b1, 6'd63);
    push_item(CMD_GENERATE, '0, 1'b0, 6'd32);
    push_item(CMD_GENERATE, '0, 1'b0, 6'd1);
    push_item(CMD_GENERATE, '0, 1'b0, 6'd0);
    push_item(CMD_GENERATE, '0, 1'b0, 6'd33);
    push_item(CMD_GENERATE, '0, 1'b0, 6'd63);
    push_item(CMD_GENERATE, '0, 1'b0, 6'd31);
    // generate in the middle of seeding
    push_item(CMD_SEED, 32'h8000_0000, 1'b0, 6'd0);
    push_item(CMD_GENERATE, '0, 1'b1, 6'd32);
    push_item(CMD_SEED, 32'h7fff_ffff, 1'b1, 6'd1);
    hold_next = 1'b1;
    push_item(CMD_GENERATE, '0, 1'b0, 6'd32);
    push_item(CMD_GENERATE, '0, 1'b0, 6'd16);
    push_item(CMD_SEED, 32'h0000_0000, 1'b1, 6'd32);
    push_item(CMD_GENERATE, '1, 1'b0, 6'd32);
    push_item(CMD_GENERATE, '1, 1'b0, 6'd8);

    // seed runs (some past sixteen words) followed by number runs, plus noise
    while (pending.size() < RANDOM_ITEMS + 17) begin
      if ($urandom_range(0, 9) < 8) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 16);
        for (int k = 0; k < len; k++) push_item(CMD_SEED, pick_word(), k == len - 1, pick_bits());
        ngen = $urandom_range(3, 20);
        for (int k = 0; k < ngen; k++)
          push_item(CMD_GENERATE, $urandom, 1'($urandom), pick_bits());
      end else begin
        repeat ($urandom_range(1, 4))
          push_item(1'($urandom), pick_word(), 1'($urandom), 6'($urandom));
      end
      if (!hold_done && pending.size() > RANDOM_ITEMS / 2) begin
        hold_next = 1'b1;
        hold_done = 1'b1;
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (pending.size() != 0 || cmd_valid || expected_values.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_values.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_values.size());
      errors++;
    end
    if (errors == 0) begin
      $display("well512a_random_generator verification clean");
    end else begin
      $display("well512a_random_generator verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
src/wrg_pkg.sv
src/wrg_ram.sv
src/wrg_ctrl.sv
src/wrg_datapath.sv
src/well512a_random_generator.sv
src/wrg_checker.sv
dv/testbench.sv
